/* rtl/dpd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dpd_pkg
// Types and constants shared by the debug packet deframer modules.
// ----------------------------------------------------------------------------
package dpd_pkg;

  localparam logic [7:0] MARK_START   = 8'hAA;
  localparam logic [7:0] MARK_HDR_END = 8'hBB;
  localparam logic [7:0] MARK_TRAILER = 8'hCC;

  localparam logic [23:0] MAX_PAYLOAD_RESET = 24'd4096;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_TYPE,
    PH_LEN_HI,
    PH_LEN_MID,
    PH_LEN_LO,
    PH_HDR_END,
    PH_PAYLOAD,
    PH_TRAILER
  } phase_t;

  typedef enum logic [2:0] {
    ST_HDR_OK,
    ST_STORED,
    ST_DROPPED,
    ST_DONE,
    ST_BAD_START,
    ST_BAD_HDR_END,
    ST_BAD_TRAILER
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  packet_type;
    logic [23:0] packet_length;
    logic [7:0]  data_byte;
    logic [23:0] data_index;
    logic        last;
  } result_t;

endpackage : dpd_pkg
`default_nettype wire

/* rtl/dpd_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dpd_parser
// Packet state machine: consumes one byte per step and forms its status.
// ----------------------------------------------------------------------------
module dpd_parser import dpd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire logic [7:0]  rx_byte,
  input  wire logic [23:0] max_payload,
  output result_t          result
);

  phase_t      phase_r,  phase_nxt;
  logic [7:0]  type_r,   type_nxt;
  logic [23:0] length_r, length_nxt;
  logic [23:0] count_r,  count_nxt;
  logic [23:0] count_inc;

  assign count_inc = count_r + 24'd1;

  // next state
  always_comb begin
    phase_nxt  = phase_r;
    type_nxt   = type_r;
    length_nxt = length_r;
    count_nxt  = count_r;
    unique case (phase_r)
      PH_HUNT: begin
        if (rx_byte == MARK_START) begin
          type_nxt   = '0;
          length_nxt = '0;
          count_nxt  = '0;
          phase_nxt  = PH_TYPE;
        end
      end
      PH_TYPE: begin
        type_nxt  = rx_byte;
        phase_nxt = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        length_nxt = {length_r[15:0], rx_byte};
        phase_nxt  = PH_LEN_MID;
      end
      PH_LEN_MID: begin
        length_nxt = {length_r[15:0], rx_byte};
        phase_nxt  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        length_nxt = {length_r[15:0], rx_byte};
        phase_nxt  = PH_HDR_END;
      end
      PH_HDR_END: begin
        if (rx_byte == MARK_HDR_END) begin
          count_nxt = '0;
          phase_nxt = (length_r == '0) ? PH_TRAILER : PH_PAYLOAD;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_PAYLOAD: begin
        count_nxt = count_inc;
        if (count_inc >= length_r) phase_nxt = PH_TRAILER;
      end
      PH_TRAILER: begin
        phase_nxt = PH_HUNT;
      end
      default: phase_nxt = PH_HUNT;
    endcase
  end

  // result for the current byte
  always_comb begin
    result               = '0;
    result.status        = ST_HDR_OK;
    result.packet_type   = type_nxt;
    result.packet_length = length_nxt;
    unique case (phase_r)
      PH_HUNT: begin
        result.packet_type   = '0;
        result.packet_length = '0;
        if (rx_byte != MARK_START) begin
          result.status = ST_BAD_START;
          result.last   = 1'b1;
        end
      end
      PH_HDR_END: begin
        if (rx_byte != MARK_HDR_END) begin
          result.status = ST_BAD_HDR_END;
          result.last   = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        result.data_byte  = rx_byte;
        result.data_index = count_r;
        result.status     = (count_r < max_payload) ? ST_STORED : ST_DROPPED;
      end
      PH_TRAILER: begin
        result.status = (rx_byte == MARK_TRAILER) ? ST_DONE : ST_BAD_TRAILER;
        result.last   = 1'b1;
      end
      default: result.status = ST_HDR_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      type_r   <= '0;
      length_r <= '0;
      count_r  <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      type_r   <= type_nxt;
      length_r <= length_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule : dpd_parser
`default_nettype wire

/* rtl/debug_packet_deframer_unit.sv */
`default_nettype none
// data path: an accepted byte is held in the input register, then stepped
// through the parser into the result register, where its status waits to be taken
// throughput: one byte per cycle while the output is free for the parser step
// the input register, if empty, can still take a byte while a status waits to be taken
// reset: synchronous active-low rst_n clears both stages and returns the
// parser to hunting for the start marker; max_payload resets to 4096
// ----------------------------------------------------------------------------
// debug_packet_deframer_unit
// Parses a serial byte stream into debug packets, one status beat per byte.
// ----------------------------------------------------------------------------
module debug_packet_deframer_unit import dpd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [23:0] cfg_wdata,      // max_payload
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,       // rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // status[2:0], packet_type[10:3], packet_length[34:11],
  // data_byte[42:35], data_index[66:43], zero pad[71:67]
  output logic [71:0]      out_tdata,
  output logic             out_tlast
);

  logic [23:0] max_payload_val_r;
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        out_valid_r;
  result_t     out_res_r;
  result_t     res;
  logic        out_free;
  logic        step;

  assign out_free  = !out_valid_r || out_tready;
  assign step      = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_val_r <= MAX_PAYLOAD_RESET;
    end else if (cfg_we) begin
      max_payload_val_r <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (step) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) s1_byte_r <= in_tdata;
  end

  dpd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .rx_byte     (s1_byte_r),
    .max_payload (max_payload_val_r),
    .result      (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) out_res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_res_r.last;
  assign out_tdata  = {5'd0, out_res_r.data_index, out_res_r.data_byte,
                       out_res_r.packet_length, out_res_r.packet_type,
                       out_res_r.status};

  a_last_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_res_r.status == ST_DONE ||
                                  out_res_r.status == ST_BAD_START ||
                                  out_res_r.status == ST_BAD_HDR_END ||
                                  out_res_r.status == ST_BAD_TRAILER)))
    else $error("tlast disagrees with status");

  a_hunt_zero_header: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_res_r.status == ST_BAD_START) |->
      (out_res_r.packet_type == '0 && out_res_r.packet_length == '0))
    else $error("bad start carries header fields");

  a_data_only_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_res_r.status != ST_STORED && out_res_r.status != ST_DROPPED)
      |-> (out_res_r.data_byte == '0 && out_res_r.data_index == '0))
    else $error("data fields set outside payload");

  a_stage_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_free) |=> out_valid_r)
    else $error("stepped byte produced no status");

endmodule : debug_packet_deframer_unit
`default_nettype wire
